@@ rtl/core/mked_pkg.sv @@
// shared types and constants for the multi-key edge debouncer
package mked_pkg;

   localparam int NUM_CODES = 4;
   localparam int PIN_W     = 4;
   localparam int LINE_W    = 4;
   localparam int CODE_W    = 10;
   localparam int TICKS_W   = 8;
   localparam int KEYS_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_TICK = 1'b1
   } mked_cmd_type;

   typedef enum logic {
      KIND_ANSWER = 1'b0,
      KIND_EVENT  = 1'b1
   } mked_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEYS_IN_USE    = 3'd0,
      REG_DEBOUNCE_TICKS = 3'd1,
      REG_KEY_CODE_0     = 3'd2,
      REG_KEY_CODE_1     = 3'd3,
      REG_KEY_CODE_2     = 3'd4,
      REG_KEY_CODE_3     = 3'd5
   } mked_reg_type;

   typedef struct packed {
      mked_cmd_type      command;
      logic [LINE_W-1:0] line;
      logic [PIN_W-1:0]  pin_levels;
   } mked_req_type;

   typedef struct packed {
      mked_kind_type     kind;
      logic              handled;
      logic [CODE_W-1:0] key_code;
      logic              pressed;
      logic              last;
   } mked_rsp_type;

   typedef struct packed {
      logic [KEYS_W-1:0]                 keys_in_use;
      logic [TICKS_W-1:0]                debounce_ticks;
      logic [NUM_CODES-1:0][CODE_W-1:0]  key_code;
   } mked_cfg_type;

   typedef struct packed {
      logic load;
      logic step;
   } mked_tmr_ctl_type;

endpackage

@@ rtl/core/mked_csr_regs.sv @@
// configuration register file for the multi-key edge debouncer
module mked_csr_regs
   import mked_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output mked_cfg_type         cfg
);

   mked_cfg_type cfg_ff;
   mked_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KEYS_IN_USE:    cfg_in.keys_in_use    = csr_data[KEYS_W-1:0];
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_data[TICKS_W-1:0];
            REG_KEY_CODE_0:     cfg_in.key_code[0]    = csr_data[CODE_W-1:0];
            REG_KEY_CODE_1:     cfg_in.key_code[1]    = csr_data[CODE_W-1:0];
            REG_KEY_CODE_2:     cfg_in.key_code[2]    = csr_data[CODE_W-1:0];
            REG_KEY_CODE_3:     cfg_in.key_code[3]    = csr_data[CODE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keys_in_use    <= KEYS_W'(4);
         cfg_ff.debounce_ticks <= TICKS_W'(2);
         cfg_ff.key_code       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/mked_timer_unit.sv @@
// per-key countdown store with one shared decrement and expiry compare
module mked_timer_unit
   import mked_pkg::*;
#(
   parameter int MAX_KEYS = 4,
   parameter int IDX_W    = 2
)(
   input  logic               clock,
   input  logic               reset,
   input  mked_tmr_ctl_type   ctl,
   input  logic [IDX_W-1:0]   idx,
   input  logic [TICKS_W-1:0] load_val,
   output logic               fire
);

   logic [MAX_KEYS-1:0][TICKS_W-1:0] cd_ff;
   logic [MAX_KEYS-1:0][TICKS_W-1:0] cd_in;
   logic [TICKS_W-1:0]               cd_sel;
   logic                             running;

   assign cd_sel  = cd_ff[idx];
   assign running = (cd_sel != '0);
   assign fire    = ctl.step && (cd_sel == TICKS_W'(1));

   always_comb begin
      cd_in = cd_ff;
      if (ctl.load) begin
         cd_in[idx] = load_val;
      end else if (ctl.step && running) begin
         cd_in[idx] = cd_sel - TICKS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff <= '0;
      end else begin
         cd_ff <= cd_in;
      end
   end

endmodule

@@ rtl/core/multi_key_edge_debouncer_core.sv @@
// top level of the multi-key edge debouncer: sequencer, result register, config
//
//   channel  ports          direction  transfer
//   request  req_valid/req_stall/req_data  in   valid & !stall
//   response rsp_valid/rsp_stall/rsp_data  out  valid & !stall
//   config   csr_valid/csr_ready/csr_index/csr_data  in  valid & ready
//
// an edge is accepted, then the countdown load and answer wait for a free response
// a tick steps every countdown through the shared decrementer key by key, then
// emits one event per expired key up to the last expiry and goes idle
// reset clears all countdowns and loads the register defaults
// a stalled response holds the sequencer before its next result; requests are taken
// only while the sequencer is idle
module multi_key_edge_debouncer_core
   import mked_pkg::*;
#(
   parameter int MAX_KEYS = 4
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mked_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mked_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_KEYS - 1);
   localparam logic [4:0] MAX_KEYS_V = 5'(MAX_KEYS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EDGE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   mked_req_type       item_ff, item_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MAX_KEYS-1:0] fire_ff, fire_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mked_rsp_type       rsp_data_ff, rsp_data_in;

   mked_cfg_type       cfg;
   mked_tmr_ctl_type   tmr_ctl;
   logic [IDX_W-1:0]   tmr_idx;
   logic [TICKS_W-1:0] load_val;
   logic               fire;

   logic               out_free;
   logic               handled;
   logic [4:0]         line_v;
   logic [4:0]         key_v;
   logic [CODE_W-1:0]  key_code_sel;
   logic               pin_sel;
   logic [MAX_KEYS-1:0] fire_rest;

   mked_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mked_timer_unit #(
      .MAX_KEYS (MAX_KEYS),
      .IDX_W    (IDX_W)
   ) u_timer (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tmr_ctl),
      .idx      (tmr_idx),
      .load_val (load_val),
      .fire     (fire)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign line_v   = {1'b0, item_ff.line};
   assign handled  = (line_v < {2'b00, cfg.keys_in_use}) && (line_v < MAX_KEYS_V);
   assign load_val = (cfg.debounce_ticks == '0) ? TICKS_W'(1) : cfg.debounce_ticks;

   assign key_v        = 5'(tmr_idx);
   assign key_code_sel = (key_v < 5'(NUM_CODES)) ? cfg.key_code[key_v[1:0]] : '0;
   assign pin_sel      = (key_v < 5'(PIN_W)) ? item_ff.pin_levels[key_v[1:0]] : 1'b0;

   always_comb begin
      fire_rest         = fire_ff;
      fire_rest[idx_ff] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      fire_in      = fire_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tmr_ctl      = '0;
      tmr_idx      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               idx_in  = '0;
               fire_in = '0;
               state_in = (req_data.command == CMD_TICK) ? ST_SCAN : ST_EDGE;
            end
         end
         ST_EDGE: begin
            tmr_idx = item_ff.line[IDX_W-1:0];
            if (out_free) begin
               tmr_ctl.load         = handled;
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = KIND_ANSWER;
               rsp_data_in.handled  = handled;
               rsp_data_in.key_code = handled ? key_code_sel : '0;
               rsp_data_in.pressed  = 1'b0;
               rsp_data_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         ST_SCAN: begin
            tmr_ctl.step    = 1'b1;
            fire_in[idx_ff] = fire;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (fire_ff == '0) begin
               state_in = ST_IDLE;
            end else if (fire_ff[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.kind     = KIND_EVENT;
                  rsp_data_in.handled  = 1'b0;
                  rsp_data_in.key_code = key_code_sel;
                  rsp_data_in.pressed  = !pin_sel;
                  rsp_data_in.last     = (fire_rest == '0);
                  fire_in              = fire_rest;
                  idx_in               = idx_ff + IDX_W'(1);
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         fire_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_ff      <= item_in;
         idx_ff       <= idx_in;
         fire_ff      <= fire_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

endmodule
